### hw/rtl/bvfm_pkg.sv
`default_nettype none

package bvfm_pkg;

   localparam int SAMPLE_BITS    = 12;
   localparam int DEBOUNCE_COUNT = 10;
   localparam int TICK_BITS      = $clog2(DEBOUNCE_COUNT + 2);
   localparam int CODE_BITS      = 8;
   localparam int CSR_INDEX_BITS = 4;
   localparam int REQ_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS  = 16;

   localparam logic [TICK_BITS-1:0] TICK_CONFIRM = TICK_BITS'(DEBOUNCE_COUNT);
   localparam logic [TICK_BITS-1:0] TICK_SAT     = TICK_BITS'(DEBOUNCE_COUNT + 1);

   localparam logic [CODE_BITS-1:0] CODE_NONE  = 8'h00;
   localparam logic [CODE_BITS-1:0] CODE_SET   = 8'h55;
   localparam logic [CODE_BITS-1:0] CODE_CLEAR = 8'h11;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOW_ENTER      = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOW_EXIT       = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HIGH_EXIT      = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HIGH_ENTER     = 4'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NET_LOW_ENTER  = 4'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NET_LOW_EXIT   = 4'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NET_HIGH_EXIT  = 4'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NET_HIGH_ENTER = 4'd7;

   typedef logic [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      sample_type low_enter;
      sample_type low_exit;
      sample_type high_exit;
      sample_type high_enter;
      sample_type net_low_enter;
      sample_type net_low_exit;
      sample_type net_high_exit;
      sample_type net_high_enter;
   } levels_type;

   localparam levels_type LEVELS_RESET = '{
      low_enter:      SAMPLE_BITS'(1435),
      low_exit:       SAMPLE_BITS'(1541),
      high_exit:      SAMPLE_BITS'(3235),
      high_enter:     SAMPLE_BITS'(3311),
      net_low_enter:  SAMPLE_BITS'(1780),
      net_low_exit:   SAMPLE_BITS'(1895),
      net_high_exit:  SAMPLE_BITS'(3155),
      net_high_enter: SAMPLE_BITS'(3230)
   };

   typedef struct packed {
      logic                 raw_low;
      logic                 raw_high;
      logic                 held_low;
      logic                 held_high;
      logic [TICK_BITS-1:0] fault_ticks;
      logic [TICK_BITS-1:0] clear_ticks;
      logic                 set_recorded;
      logic                 clear_recorded;
      logic [CODE_BITS-1:0] detect_code;
      logic                 net_low;
      logic                 net_high;
   } state_type;

   localparam state_type STATE_RESET = '{
      raw_low:        1'b0,
      raw_high:       1'b0,
      held_low:       1'b0,
      held_high:      1'b0,
      fault_ticks:    '0,
      clear_ticks:    '0,
      set_recorded:   1'b0,
      clear_recorded: 1'b0,
      detect_code:    CODE_NONE,
      net_low:        1'b1,
      net_high:       1'b1
   };

   // field order matches rsp_tdata from the lowest bit up, hence reversed here
   typedef struct packed {
      logic [CODE_BITS-1:0] record_code;
      logic                 record_write;
      logic                 net_high_flag;
      logic                 net_low_flag;
      logic                 comm_disable;
      logic                 high_code_active;
      logic                 low_code_active;
      logic                 high_fault;
      logic                 low_fault;
   } result_type;

endpackage

`default_nettype wire

### hw/rtl/bvfm_eval.sv
`default_nettype none

module bvfm_eval (
   input  wire bvfm_pkg::sample_type sample,
   input  wire bvfm_pkg::levels_type levels,
   input  wire bvfm_pkg::state_type  state,
   output bvfm_pkg::state_type       state_next,
   output bvfm_pkg::result_type      result
);
   import bvfm_pkg::*;

   logic           unheld;
   logic           raw_low_n, raw_high_n;
   logic           in_low_band, in_high_band;
   logic           net_low_n, net_high_n;
   logic           write;
   state_type      st;
   logic [TICK_BITS-1:0] ticks_inc;

   assign unheld       = !state.held_high && !state.held_low;
   assign in_low_band  = (sample >= levels.low_enter) && (sample < levels.low_exit);
   assign in_high_band = (sample > levels.high_exit) && (sample <= levels.high_enter);

   // fault band classification, first match wins
   always_comb begin
      raw_low_n  = state.raw_low;
      raw_high_n = state.raw_high;
      if (sample > levels.high_enter) begin
         raw_low_n = 1'b0; raw_high_n = 1'b1;
      end else if (sample < levels.low_enter) begin
         raw_low_n = 1'b1; raw_high_n = 1'b0;
      end else if (sample >= levels.low_exit && sample <= levels.high_exit) begin
         raw_low_n = 1'b0; raw_high_n = 1'b0;
      end else if (in_low_band && state.held_low) begin
         raw_low_n = 1'b1; raw_high_n = 1'b0;
      end else if (in_high_band && state.held_high) begin
         raw_low_n = 1'b0; raw_high_n = 1'b1;
      end else if (in_low_band && unheld) begin
         raw_low_n = 1'b0; raw_high_n = 1'b0;
      end else if (sample > levels.high_exit && sample < levels.high_enter && unheld) begin
         raw_low_n = 1'b0; raw_high_n = 1'b0;
      end
   end

   // network flags, hysteresis on the previous flag values
   always_comb begin
      net_low_n  = state.net_low;
      net_high_n = state.net_high;
      if (sample < levels.net_low_enter) begin
         net_low_n = 1'b1; net_high_n = 1'b0;
      end else if (sample > levels.net_low_enter && sample < levels.net_low_exit
                   && state.net_low) begin
         net_low_n = 1'b1; net_high_n = 1'b0;
      end else if (sample > levels.net_low_exit && sample < levels.net_high_exit) begin
         net_low_n = 1'b0; net_high_n = 1'b0;
      end else if (sample > levels.net_high_enter) begin
         net_low_n = 1'b0; net_high_n = 1'b1;
      end else if (sample > levels.net_high_exit && sample < levels.net_high_enter
                   && state.net_high) begin
         net_low_n = 1'b0; net_high_n = 1'b1;
      end
   end

   // debounce: one saturating counter per phase
   always_comb begin
      st          = state;
      write       = 1'b0;
      ticks_inc   = '0;
      st.raw_low  = raw_low_n;
      st.raw_high = raw_high_n;
      st.net_low  = net_low_n;
      st.net_high = net_high_n;
      if (raw_low_n || raw_high_n) begin
         st.clear_ticks    = '0;
         st.clear_recorded = 1'b0;
         ticks_inc = (state.fault_ticks < TICK_SAT) ? state.fault_ticks + 1'b1
                                                    : state.fault_ticks;
         st.fault_ticks = ticks_inc;
         if (ticks_inc >= TICK_CONFIRM) begin
            if (raw_low_n) begin
               st.held_low = 1'b1;
            end else begin
               st.held_high = 1'b1;
            end
            st.fault_ticks = TICK_SAT;
            st.detect_code = CODE_SET;
            if (!state.set_recorded) begin
               st.set_recorded = 1'b1;
               write           = 1'b1;
            end
         end
      end else begin
         st.fault_ticks  = '0;
         st.set_recorded = 1'b0;
         ticks_inc = (state.clear_ticks < TICK_SAT) ? state.clear_ticks + 1'b1
                                                    : state.clear_ticks;
         st.clear_ticks = ticks_inc;
         if (ticks_inc >= TICK_CONFIRM) begin
            st.held_low    = 1'b0;
            st.held_high   = 1'b0;
            st.clear_ticks = TICK_SAT;
            st.detect_code = CODE_CLEAR;
            if (!state.clear_recorded) begin
               st.clear_recorded = 1'b1;
               write             = 1'b1;
            end
         end
      end
   end

   assign state_next = st;

   always_comb begin
      result.low_fault        = st.held_low;
      result.high_fault       = st.held_high;
      result.low_code_active  = st.held_low;
      result.high_code_active = st.held_high && !st.held_low;
      result.comm_disable     = st.held_low || st.held_high;
      result.net_low_flag     = st.net_low;
      result.net_high_flag    = st.net_high;
      result.record_write     = write;
      result.record_code      = st.detect_code;
   end

endmodule

`default_nettype wire

### hw/rtl/battery_voltage_fault_monitor_unit.sv
// the result for an accepted sample is registered into the result queue and shows on rsp_tdata at its head
// throughput: one sample per cycle while the result queue is not full, the state update for each word is a single pass
// a two-word result queue lets a word be taken while the previous result waits
// reset (synchronous, active high) restores the default levels and fault state
// and empties the result queue
`default_nettype none

module battery_voltage_fault_monitor_unit (
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire                                       req_tvalid,
   output logic                                      req_tready,
   // [11:0] supply_sample, [15:12] zero
   input  wire [bvfm_pkg::REQ_DATA_BITS-1:0]         req_tdata,
   output logic                                      rsp_tvalid,
   input  wire                                       rsp_tready,
   // [0] low_fault, [1] high_fault, [2] low_code_active, [3] high_code_active,
   // [4] comm_disable, [5] net_low_flag, [6] net_high_flag, [7] record_write,
   // [15:8] record_code
   output logic [bvfm_pkg::RSP_DATA_BITS-1:0]        rsp_tdata,
   input  wire                                       csr_valid,
   output logic                                      csr_ready,
   input  wire [bvfm_pkg::CSR_INDEX_BITS-1:0]        csr_index,
   input  wire [bvfm_pkg::SAMPLE_BITS-1:0]           csr_data
);
   import bvfm_pkg::*;

   levels_type levels_ff, levels_in;
   state_type  state_ff, state_in;
   result_type result;
   result_type queue_ff [2];
   result_type queue_in [2];
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign csr_ready  = 1'b1;
   assign req_tready = (count_ff != 2'd2);
   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = queue_ff[0];
   assign push       = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;

   bvfm_eval u_eval (
      .sample     (req_tdata[SAMPLE_BITS-1:0]),
      .levels     (levels_ff),
      .state      (state_ff),
      .state_next (state_in),
      .result     (result)
   );

   always_comb begin
      levels_in = levels_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_LOW_ENTER:      levels_in.low_enter      = csr_data;
            CSR_LOW_EXIT:       levels_in.low_exit       = csr_data;
            CSR_HIGH_EXIT:      levels_in.high_exit      = csr_data;
            CSR_HIGH_ENTER:     levels_in.high_enter     = csr_data;
            CSR_NET_LOW_ENTER:  levels_in.net_low_enter  = csr_data;
            CSR_NET_LOW_EXIT:   levels_in.net_low_exit   = csr_data;
            CSR_NET_HIGH_EXIT:  levels_in.net_high_exit  = csr_data;
            CSR_NET_HIGH_ENTER: levels_in.net_high_enter = csr_data;
            default:            levels_in = levels_ff;
         endcase
      end
   end

   // head of the queue is always slot 0
   always_comb begin
      queue_in = queue_ff;
      count_in = count_ff;
      case ({push, pop})
         2'b10: begin
            if (count_ff == 2'd0) begin
               queue_in[0] = result;
            end else begin
               queue_in[1] = result;
            end
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            queue_in[0] = queue_ff[1];
            count_in    = count_ff - 2'd1;
         end
         2'b11: begin
            queue_in[0] = result;
         end
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= LEVELS_RESET;
         state_ff  <= STATE_RESET;
         count_ff  <= 2'd0;
      end else begin
         levels_ff <= levels_in;
         count_ff  <= count_in;
         if (push) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      queue_ff <= queue_in;
   end

`ifndef SYNTHESIS
   a_write_code : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[7] |-> rsp_tdata[15:8] == CODE_SET
                                     || rsp_tdata[15:8] == CODE_CLEAR)
      else $error("record write without a set or clear code");

   a_ticks_excl : assert property (@(posedge clock) disable iff (reset)
      state_ff.fault_ticks != '0 |-> state_ff.clear_ticks == '0)
      else $error("fault and clear counters both running");

   a_ticks_sat : assert property (@(posedge clock) disable iff (reset)
      state_ff.fault_ticks <= TICK_SAT && state_ff.clear_ticks <= TICK_SAT)
      else $error("debounce counter past saturation");

   a_queue_full : assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |=> !$past(push))
      else $error("word taken into a full result queue");
`endif

endmodule

`default_nettype wire
